FILE: rtl/core/rk4_pkg.sv
// ----------------------------------------------------------------------------
// RK4 Riccati step package
// Shared defaults, register indexes, sequencer states and step codes for the
// fixed-point fourth-order Runge-Kutta integrator.
// ----------------------------------------------------------------------------
package rk4_pkg;

    localparam int DEF_WORD_BITS = 48;
    localparam int DEF_FRAC_BITS = 32;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [63:0] STEP_RESET = 64'd429497;
    localparam logic [63:0] END_RESET  = 64'd6071868024;

    localparam int DIVISOR = 6;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_X = 2'd0,
        REG_START_Y = 2'd1,
        REG_STEP    = 2'd2,
        REG_END_X   = 2'd3
    } cfg_reg_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ISSUE = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_POST  = 8'b0000_1000,
        ST_ACC   = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_FIN   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        OP_K1  = 3'd0,
        OP_H1  = 3'd1,
        OP_K2  = 3'd2,
        OP_H2  = 3'd3,
        OP_K3  = 3'd4,
        OP_H3  = 3'd5,
        OP_K4  = 3'd6,
        OP_SUM = 3'd7
    } op_t;

endpackage

FILE: rtl/core/rk4_riccati_step.sv
// ----------------------------------------------------------------------------
// RK4 Riccati step
// Fixed-point fourth-order Runge-Kutta integrator for dy/dx = 1 + y*y with
// saturating arithmetic and a single shared multiplier.
// ----------------------------------------------------------------------------
// A step item makes eight passes through the shared multiplier, with four accumulate
// steps, then one step per 12-bit digit of the divide by six, one step to update the
// point and one to load the result.
// A restart item, or a step refused past the end point, goes straight to the result load.
// One item is in work at a time; a new item can be accepted in the cycle after the result is loaded.
// Reset clears the point to zero and loads the register defaults.
// ----------------------------------------------------------------------------
module rk4_riccati_step
    import rk4_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [WORD_BITS-1:0]        cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        restart,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [WORD_BITS-1:0] x_value,
    output logic signed [WORD_BITS-1:0] y_value,
    output logic                        done_res
);

    localparam int DIG  = 12;
    localparam int NDIG = (WORD_BITS + DIG - 1) / DIG;
    localparam int DW   = NDIG * DIG;
    localparam int DCW  = $clog2(NDIG);
    localparam int RW   = $clog2(DIVISOR);
    localparam int VW   = RW + DIG;
    localparam int RSH  = VW + 3;

    localparam logic [VW:0] RECIP = (VW+1)'(((1 << RSH) + DIVISOR - 1) / DIVISOR);

    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] ONE_Q =
        (FRAC_BITS >= WORD_BITS - 1) ? WMAX : $signed(WORD_BITS'(1) << FRAC_BITS);

    function automatic logic signed [WORD_BITS-1:0] sat_add(
        input logic signed [WORD_BITS-1:0] p,
        input logic signed [WORD_BITS-1:0] r
    );
        logic signed [WORD_BITS:0] sum;
        sum = {p[WORD_BITS-1], p} + {r[WORD_BITS-1], r};
        if (sum[WORD_BITS] != sum[WORD_BITS-1])
        begin
            return sum[WORD_BITS] ? WMIN : WMAX;
        end
        return sum[WORD_BITS-1:0];
    endfunction

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic signed [WORD_BITS-1:0] sx_reg, sy_reg, ex_reg;
    logic [WORD_BITS-2:0]        h_reg;

    logic signed [WORD_BITS-1:0] x_reg, x_next;
    logic signed [WORD_BITS-1:0] y_reg, y_next;
    logic                        flag_reg, flag_next;
    logic [DCW-1:0]              dcnt_reg, dcnt_next;
    logic                        out_valid_reg, out_valid_next;

    logic signed [WORD_BITS-1:0] t_reg, t_next;
    logic signed [WORD_BITS-1:0] k_reg, k_next;
    logic signed [WORD_BITS-1:0] s_reg, s_next;
    logic [DW-1:0]               dmag_reg, dmag_next;
    logic [RW-1:0]               drem_reg, drem_next;
    logic                        dneg_reg, dneg_next;
    logic signed [WORD_BITS-1:0] xo_reg, yo_reg;
    logic                        do_reg;

    logic                        mul_start;
    logic                        mul_done;
    logic signed [WORD_BITS-1:0] mul_a, mul_b, mul_r;
    logic [WORD_BITS-1:0]        mul_mag;
    logic signed [WORD_BITS-1:0] h_s;
    logic [VW-1:0]               dv;
    logic [2*VW:0]               dprod;
    logic [DIG-1:0]              dq;
    logic [RW-1:0]               dr;
    logic signed [WORD_BITS-1:0] quot;
    logic                        in_acc;
    logic                        out_load;

    assign h_s    = $signed({1'b0, h_reg});
    assign in_acc = in_valid && in_ready;

    rk4_mul #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_r)
    );

    always_comb
    begin
        unique case (op_reg)
            OP_K1, OP_K2, OP_K3, OP_K4:
            begin
                mul_a = t_reg;
                mul_b = t_reg;
            end
            OP_H1, OP_H2, OP_H3:
            begin
                mul_a = k_reg;
                mul_b = h_s;
            end
            OP_SUM:
            begin
                mul_a = h_s;
                mul_b = s_reg;
            end
            default:
            begin
                mul_a = t_reg;
                mul_b = t_reg;
            end
        endcase
    end

    always_comb
    begin
        mul_mag = mul_r[WORD_BITS-1] ? (~mul_r + WORD_BITS'(1)) : mul_r;
        dv      = {drem_reg, dmag_reg[DW-1 -: DIG]};
        dprod   = dv * RECIP;
        dq      = dprod[RSH +: DIG];
        dr      = RW'(dv - VW'(VW'(dq) * VW'(DIVISOR)));
        quot    = dneg_reg ? $signed(WORD_BITS'(0) - dmag_reg[WORD_BITS-1:0])
                           : $signed(dmag_reg[WORD_BITS-1:0]);
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        flag_next      = flag_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg;
        t_next         = t_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        dmag_next      = dmag_reg;
        drem_next      = drem_reg;
        dneg_next      = dneg_reg;
        mul_start      = 1'b0;
        out_load       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next = OP_K1;
                    t_next  = y_reg;
                    if (restart)
                    begin
                        x_next     = sx_reg;
                        y_next     = sy_reg;
                        flag_next  = 1'b0;
                        state_next = ST_OUT;
                    end
                    else if (x_reg <= ex_reg)
                    begin
                        flag_next  = 1'b0;
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        flag_next  = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_ISSUE:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                unique case (op_reg)
                    OP_K1, OP_K2, OP_K3, OP_K4:
                    begin
                        k_next     = sat_add(ONE_Q, mul_r);
                        state_next = ST_ACC;
                    end
                    OP_H1, OP_H2:
                    begin
                        t_next     = sat_add(y_reg, mul_r >>> 1);
                        op_next    = op_t'(op_reg + 3'd1);
                        state_next = ST_ISSUE;
                    end
                    OP_H3:
                    begin
                        t_next     = sat_add(y_reg, mul_r);
                        op_next    = op_t'(op_reg + 3'd1);
                        state_next = ST_ISSUE;
                    end
                    OP_SUM:
                    begin
                        dneg_next  = mul_r[WORD_BITS-1];
                        dmag_next  = DW'(mul_mag);
                        drem_next  = '0;
                        dcnt_next  = DCW'(NDIG - 1);
                        state_next = ST_DIV;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ACC:
            begin
                unique case (op_reg)
                    OP_K1:        s_next = k_reg;
                    OP_K2, OP_K3: s_next = sat_add(s_reg, sat_add(k_reg, k_reg));
                    OP_K4:        s_next = sat_add(s_reg, k_reg);
                    default:      s_next = s_reg;
                endcase
                op_next    = op_t'(op_reg + 3'd1);
                state_next = ST_ISSUE;
            end
            ST_DIV:
            begin
                drem_next = dr;
                dmag_next = {dmag_reg[DW-DIG-1:0], dq};
                if (dcnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    dcnt_next = dcnt_reg - DCW'(1);
                end
            end
            ST_FIN:
            begin
                y_next     = sat_add(y_reg, quot);
                x_next     = sat_add(x_reg, h_s);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_K1;
            x_reg         <= '0;
            y_reg         <= '0;
            flag_reg      <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            h_reg         <= (WORD_BITS-1)'(STEP_RESET);
            ex_reg        <= $signed(WORD_BITS'(END_RESET));
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            flag_reg      <= flag_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_START_X: sx_reg <= $signed(cfg_data);
                    REG_START_Y: sy_reg <= $signed(cfg_data);
                    REG_STEP:    h_reg  <= cfg_data[WORD_BITS-2:0];
                    REG_END_X:   ex_reg <= $signed(cfg_data);
                    default:     h_reg  <= h_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        k_reg    <= k_next;
        s_reg    <= s_next;
        dmag_reg <= dmag_next;
        drem_reg <= drem_next;
        dneg_reg <= dneg_next;
        if (out_load)
        begin
            xo_reg <= x_reg;
            yo_reg <= y_reg;
            do_reg <= flag_reg;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign x_value   = xo_reg;
    assign y_value   = yo_reg;
    assign done_res  = do_reg;

    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside the wait state");

    a_restart_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && restart) |=> (state_reg == ST_OUT))
        else $error("restart item did not go straight to the result");

    a_div_on_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (op_reg == OP_SUM))
        else $error("divide running before the weighted sum");

endmodule

FILE: rtl/core/rk4_mul.sv
// ----------------------------------------------------------------------------
// RK4 shared fixed-point multiplier
// Signed saturating multiply with floor scaling, built from four half-width
// partial products accumulated in turn, then one finishing step.
// ----------------------------------------------------------------------------
module rk4_mul
    import rk4_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [WORD_BITS-1:0] a,
    input  logic signed [WORD_BITS-1:0] b,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] result
);

    localparam int LIMB = (WORD_BITS + 1) / 2;
    localparam int PW   = 2 * WORD_BITS;

    localparam logic [2:0]           LAST_CNT = 3'd4;
    localparam logic [PW-1:0]        TOP_MAG  = PW'(1) << (WORD_BITS - 1);
    localparam logic [PW-1:0]        REM_MASK = (PW'(1) << FRAC_BITS) - PW'(1);
    localparam logic [WORD_BITS-1:0] WMAX     = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WMIN     = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [WORD_BITS-1:0]        ma_reg;
    logic [WORD_BITS-1:0]        mb_reg;
    logic                        neg_reg;
    logic [PW-1:0]               prod_reg;
    logic [2:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic signed [WORD_BITS-1:0] result_reg;

    logic [LIMB-1:0]   a_limb;
    logic [LIMB-1:0]   b_limb;
    logic [2*LIMB-1:0] pp;
    logic [PW-1:0]     pp_sh;
    logic [PW-1:0]     q;
    logic [PW-1:0]     qn;
    logic              rem_nz;
    logic [WORD_BITS-1:0] fin;

    always_comb
    begin
        a_limb = cnt_reg[1] ? LIMB'(ma_reg >> LIMB) : ma_reg[LIMB-1:0];
        b_limb = cnt_reg[0] ? LIMB'(mb_reg >> LIMB) : mb_reg[LIMB-1:0];
        pp     = a_limb * b_limb;
        pp_sh  = (PW'(pp) << (cnt_reg[1] ? LIMB : 0)) << (cnt_reg[0] ? LIMB : 0);
        q      = prod_reg >> FRAC_BITS;
        rem_nz = |(prod_reg & REM_MASK);
        qn     = q + PW'(rem_nz);
        if (neg_reg)
        begin
            fin = (qn > TOP_MAG) ? WMIN : WORD_BITS'(PW'(0) - qn);
        end
        else
        begin
            fin = (q > (TOP_MAG - PW'(1))) ? WMAX : q[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            ma_reg   <= a[WORD_BITS-1] ? (~a + WORD_BITS'(1)) : a;
            mb_reg   <= b[WORD_BITS-1] ? (~b + WORD_BITS'(1)) : b;
            neg_reg  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST_CNT)
            begin
                result_reg <= $signed(fin);
            end
            else
            begin
                prod_reg <= prod_reg + pp_sh;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
